FILE: design/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int NumRounds = 14;
  localparam int KeyWords  = 60;
  localparam int KeyRegs   = 4;

  typedef logic [7:0]   byte_t;
  typedef logic [31:0]  word_t;
  typedef logic [127:0] block_t;

  localparam logic [1:0] RegKey0 = 2'd0;
  localparam logic [1:0] RegKey1 = 2'd1;
  localparam logic [1:0] RegKey2 = 2'd2;
  localparam logic [1:0] RegKey3 = 2'd3;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  localparam logic [2047:0] SboxFlat = {
    128'h16bb54b00f2d99416842e6bf0d89a18c, 128'hdf2855cee9871e9b948ed9691198f8e1,
    128'h9e1dc186b95735610ef6034866b53e70, 128'h8a8bbd4b1f74dde8c6b4a61c2e2578ba,
    128'h08ae7a65eaf4566ca94ed58d6d37c8e7, 128'h79e4959162acd3c25c2406490a3a32e0,
    128'hdb0b5ede14b8ee4688902a22dc4f8160, 128'h73195d643d7ea7c41744975fec130ccd,
    128'hd2f3ff1021dab6bcf5389d928f40a351, 128'ha89f3c507f02f94585334d43fbaaefd0,
    128'hcf584c4a39becb6a5bb1fc20ed00d153, 128'h842fe329b3d63b52a05a6e1b1a2c8309,
    128'h75b227ebe28012079a059618c323c704, 128'h1531d871f1e5a534ccf73f362693fdb7,
    128'hc072a49cafa2d4adf04759fa7dc982ca, 128'h76abd7fe2b670130c56f6bf27b777c63
  };

  function automatic byte_t sbox(input byte_t a);
    return SboxFlat[{a, 3'b000} +: 8];
  endfunction

  function automatic byte_t inv_sbox(input byte_t a);
    byte_t r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SboxFlat[i*8 +: 8] == a) r = i[7:0];
    end
    return r;
  endfunction

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage
`default_nettype wire

FILE: design/aes_if.sv
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source (output valid, op, block_hi, block_lo, input ready);
  modport sink   (input valid, op, block_hi, block_lo, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface
`default_nettype wire

FILE: design/aes256_block_cipher_top.sv
// AES-256 single-block cipher, encrypt or decrypt.
//
// Channels: in_ch carries op (0 encrypt, 1 decrypt) and a 128-bit block as
// block_hi/block_lo; out_ch returns result_hi/result_lo. A beat moves when
// valid and ready are both high. The key is written through cfg_we/cfg_index/
// cfg_data into four 64-bit registers. The user must write them only while the
// block is idle; the block itself does not enforce this.
//
// The initial key addition (S_LOAD) is followed by the 14 rounds (S_ROUND),
// after which the result is held on out_ch (S_DONE) until the beat is taken.
// A new block is not taken before then: in_ch is ready again only once the
// result beat is taken and the block is back in idle. After reset or a key
// write the first block first runs the key expansion (8 words loaded from the
// key, 52 computed, then a closing step) before the initial key addition.
//
// Reset clears the control state, the key registers and the schedule-ready
// flag. When the receiver stalls, the result holds in the output register and
// in_ch stays not ready until the result beat is taken.
`default_nettype none
module aes256_block_cipher_top (
  input  wire          clk,
  input  wire          rst,
  aes_in_if.sink       in_ch,
  aes_out_if.source    out_ch,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [63:0]  cfg_data
);
  import aes_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_LOAD, S_ROUND, S_DONE} state_t;

  state_t      state;
  logic [63:0] key_reg [KeyRegs];
  logic        sched_ready;
  // Round keys stored four words to a row.
  logic [127:0] rk_mem [NumRounds+1];
  logic [127:0] rk_row;
  logic [5:0]  wcnt;
  word_t       win [8];
  logic [7:0]  rcon;
  logic [3:0]  rnd;
  logic [3:0]  rd_addr;
  logic        dec;
  block_t      st;

  // Key expansion: window of the last eight words.
  word_t w_t, w_new;
  always_comb begin
    w_t = win[7];
    if (wcnt[2:0] == 3'd0) w_t = sub_word({win[7][23:0], win[7][31:24]}) ^ {rcon, 24'h0};
    else if (wcnt[2:0] == 3'd4) w_t = sub_word(win[7]);
    w_new = win[0] ^ w_t;
  end

  function automatic block_t shift_rows(input block_t s, input logic inv);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127-8*(((c+r)&3)*4+r) -: 8] = s[127-8*(c*4+r) -: 8];
        else     t[127-8*(c*4+r) -: 8] = s[127-8*(((c+r)&3)*4+r) -: 8];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s, input logic inv);
    block_t t;
    byte_t a0, a1, a2, a3, x0, x1, x2, x3, y0, y1;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8]; a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8]; a3 = s[103-32*c -: 8];
      if (inv) begin
        // Pre-condition for InvMixColumns, then forward mix.
        y0 = xtime(xtime(a0 ^ a2));
        y1 = xtime(xtime(a1 ^ a3));
        a0 = a0 ^ y0; a1 = a1 ^ y1; a2 = a2 ^ y0; a3 = a3 ^ y1;
      end
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      t[127-32*c -: 8] = x0 ^ x1 ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
      t[103-32*c -: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
    end
    return t;
  endfunction

  block_t sb, enc_next, dec_next, sr;
  always_comb begin
    for (int i = 0; i < 16; i++) sb[8*i +: 8] = sbox(st[8*i +: 8]);
    enc_next = shift_rows(sb, 1'b0);
    if (rnd != 4'(NumRounds)) enc_next = mix_columns(enc_next, 1'b0);
    enc_next = enc_next ^ rk_row;
    sr = shift_rows(st, 1'b1);
    for (int i = 0; i < 16; i++) dec_next[8*i +: 8] = inv_sbox(sr[8*i +: 8]);
    dec_next = dec_next ^ rk_row;
    if (rnd != 4'(NumRounds)) dec_next = mix_columns(dec_next, 1'b1);
  end

  assign in_ch.ready = (state == S_IDLE);

  // Round-key memory: write one row per four words, registered read.
  always_ff @(posedge clk) begin
    if (state == S_EXPAND && wcnt[1:0] == 2'd3)
      rk_mem[wcnt[5:2]] <= {win[5], win[6], win[7],
                            (wcnt < 6'd8) ? key_reg[wcnt[2:1]][31:0] : w_new};
    rk_row <= rk_mem[rd_addr];
  end

  always_comb begin
    rd_addr = 4'd0;
    if (state == S_IDLE) rd_addr = in_ch.op ? 4'(NumRounds) : 4'd0;
    else if (state == S_EXPAND) rd_addr = dec ? 4'(NumRounds) : 4'd0;
    else if (state == S_LOAD || state == S_ROUND)
      rd_addr = dec ? 4'(NumRounds) - rnd - 4'd1 : rnd + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      sched_ready <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < KeyRegs; i++) key_reg[i] <= '0;
    end else begin
      if (cfg_we) begin
        key_reg[cfg_index] <= cfg_data;
        sched_ready <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            dec <= in_ch.op;
            st  <= {in_ch.block_hi, in_ch.block_lo};
            wcnt <= '0;
            rcon <= 8'h01;
            rnd <= 4'd0;
            state <= sched_ready ? S_LOAD : S_EXPAND;
          end
        end
        S_EXPAND: begin
          // Shift the window; first eight words come from the key registers.
          for (int i = 0; i < 7; i++) win[i] <= win[i+1];
          if (wcnt < 6'd8)
            win[7] <= wcnt[0] ? key_reg[wcnt[2:1]][31:0] : key_reg[wcnt[2:1]][63:32];
          else begin
            win[7] <= w_new;
            if (wcnt[2:0] == 3'd0) rcon <= xtime(rcon);
          end
          wcnt <= wcnt + 6'd1;
          if (wcnt == 6'(KeyWords)) begin
            sched_ready <= 1'b1;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          st  <= st ^ rk_row;
          rnd <= 4'd1;
          state <= S_ROUND;
        end
        S_ROUND: begin
          st <= dec ? dec_next : enc_next;
          rnd <= rnd + 4'd1;
          if (rnd == 4'(NumRounds)) begin
            out_ch.valid <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.result_hi = st[127:64];
  assign out_ch.result_lo = st[63:0];

endmodule
`default_nettype wire

FILE: design/aes_checker.sv
`default_nettype none
module aes_checker (
  input wire         clk,
  input wire         rst,
  input wire         in_valid,
  input wire         in_ready,
  input wire         out_valid,
  input wire         out_ready,
  input wire [127:0] result
);
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result)) else $error("result dropped");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid ##14 !out_valid) else $error("result too early");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");
endmodule

bind aes256_block_cipher_top aes_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result({out_ch.result_hi, out_ch.result_lo})
);
`default_nettype wire
